### design/slse_pkg.sv
// Package for the sequential list shift engine.
// Holds the opcode, status and sequencer state codes and the result record.
// Depends on nothing; every other file of the block but slse_mem imports it.
package slse_pkg;

    localparam int OP_W       = 3;
    localparam int POS_W      = 8;
    localparam int VAL_W      = 32;
    localparam int CNT_OUT_W  = 8;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 40;   // position + entry_value, byte aligned
    localparam int OUT_DATA_W = 40;   // removed_value + entry_count, byte aligned

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_AT    = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE        = 2'd0,
        ST_INS_REFUSED = 2'd1,
        ST_REM_REFUSED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_UP_DRAIN,
        S_PLACE,
        S_RM_READ,
        S_RM_CAPT,
        S_RM_SHIFT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0]     removed;
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

endpackage

### design/slse_mem.sv
// List storage of the sequential list shift engine.
// One write port and one read port, read data registered.
// Uses no package items.
module slse_mem #(
    parameter int DEPTH       = 128,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [ENTRY_WIDTH-1:0]   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [ENTRY_WIDTH-1:0]   o_rdata
);

    logic [ENTRY_WIDTH-1:0] r_mem [DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/slse_ctrl.sv
// Sequencer of the sequential list shift engine: decodes one operation,
// checks it, and walks the list memory one entry per cycle to shift it.
// Depends on slse_pkg; drives the ports of slse_mem.
module slse_ctrl #(
    parameter int DEPTH       = 128,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [slse_pkg::OP_W-1:0]       i_opcode,
    input  logic [slse_pkg::POS_W-1:0]      i_position,
    input  logic [slse_pkg::VAL_W-1:0]      i_entry,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output slse_pkg::t_result               o_res,
    output logic                            o_mem_we,
    output logic [$clog2(DEPTH)-1:0]        o_mem_waddr,
    output logic [ENTRY_WIDTH-1:0]          o_mem_wdata,
    output logic                            o_mem_re,
    output logic [$clog2(DEPTH)-1:0]        o_mem_raddr,
    input  logic [ENTRY_WIDTH-1:0]          i_mem_rdata
);
    import slse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op;
    logic [POS_W-1:0]       r_pos;
    logic [ENTRY_WIDTH-1:0] r_val;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_at, n_at;
    logic [CW-1:0]          r_src, n_src;
    logic [CW-1:0]          r_wa, n_wa;
    logic                   r_pend, n_pend;
    t_result                r_res, n_res;

    logic [PW-1:0] at_w;
    logic [PW-1:0] count_w;
    logic          is_ins, is_rem, ins_ok, rem_ok;

    // Decode of the captured item against the current count.
    always_comb begin
        count_w = PW'(r_count);
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        at_w    = '0;
        unique case (r_op)
            OP_INS_FRONT: begin is_ins = 1'b1; at_w = '0; end
            OP_INS_BACK:  begin is_ins = 1'b1; at_w = count_w; end
            OP_INS_AT:    begin is_ins = 1'b1; at_w = PW'(r_pos); end
            OP_REM_FRONT: begin is_rem = 1'b1; at_w = '0; end
            OP_REM_BACK:  begin is_rem = 1'b1; at_w = count_w - PW'(1); end
            OP_REM_AT:    begin is_rem = 1'b1; at_w = PW'(r_pos); end
            default:      begin at_w = '0; end
        endcase
        ins_ok = (count_w < PW'(DEPTH)) && (at_w <= count_w);
        rem_ok = (r_count != '0) && (at_w < count_w);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (is_ins && ins_ok) begin
                    n_state = (at_w == count_w) ? S_PLACE : S_SHIFT_UP;
                end else if (is_rem && rem_ok) begin
                    n_state = S_RM_READ;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SHIFT_UP: begin
                if (r_src == r_at) begin
                    n_state = S_UP_DRAIN;
                end
            end
            S_UP_DRAIN: n_state = S_PLACE;
            S_PLACE:    n_state = S_RESULT;
            S_RM_READ:  n_state = S_RM_CAPT;
            S_RM_CAPT: begin
                n_state = (r_src < r_count) ? S_RM_SHIFT : S_RESULT;
            end
            S_RM_SHIFT: begin
                if (r_src >= r_count) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs, memory accesses and datapath updates.
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wa[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_src[AW-1:0];
        n_count     = r_count;
        n_at        = r_at;
        n_src       = r_src;
        n_wa        = r_wa;
        n_pend      = r_pend;
        n_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_DECODE: begin
                n_at   = at_w[CW-1:0];
                n_pend = 1'b0;
                if (is_ins) begin
                    n_src = r_count - CW'(1);
                end else begin
                    n_src = at_w[CW-1:0] + CW'(1);
                end
                n_res.removed = '0;
                n_res.count   = CNT_OUT_W'(r_count);
                if (is_ins && !ins_ok) begin
                    n_res.status = ST_INS_REFUSED;
                end else if (is_rem && !rem_ok) begin
                    n_res.status = ST_REM_REFUSED;
                end else begin
                    n_res.status = ST_DONE;
                end
            end
            S_SHIFT_UP: begin
                // Read entry src now, write it one slot higher next cycle.
                o_mem_we = r_pend;
                o_mem_re = 1'b1;
                n_wa     = r_src + CW'(1);
                n_pend   = 1'b1;
                n_src    = r_src - CW'(1);
            end
            S_UP_DRAIN: begin
                o_mem_we = 1'b1;
            end
            S_PLACE: begin
                o_mem_we      = 1'b1;
                o_mem_waddr   = r_at[AW-1:0];
                o_mem_wdata   = r_val;
                n_count       = r_count + CW'(1);
                n_res.removed = '0;
                n_res.status  = ST_DONE;
                n_res.count   = CNT_OUT_W'(r_count + CW'(1));
            end
            S_RM_READ: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_at[AW-1:0];
                n_wa        = r_at;
            end
            S_RM_CAPT: begin
                n_res.removed = VAL_W'(64'(i_mem_rdata));
                n_res.status  = ST_DONE;
                n_res.count   = CNT_OUT_W'(r_count - CW'(1));
                if (r_src < r_count) begin
                    o_mem_re = 1'b1;
                    n_src    = r_src + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            S_RM_SHIFT: begin
                // Entry read last cycle moves one slot down.
                o_mem_we = 1'b1;
                n_wa     = r_wa + CW'(1);
                if (r_src < r_count) begin
                    o_mem_re = 1'b1;
                    n_src    = r_src + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_at  <= n_at;
        r_src <= n_src;
        r_wa  <= n_wa;
        r_res <= n_res;
        if (r_state == S_IDLE && i_in_valid) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= ENTRY_WIDTH'(64'(i_entry));
        end
    end

endmodule

### design/sequential_list_shift_engine_core.sv
// Top level of the sequential list shift engine: stream ports, result register,
// sequencer and list memory. Depends on slse_pkg, slse_ctrl and slse_mem.
//
//   channel  | direction | tdata (low bit up)             | tuser
//   ---------+-----------+--------------------------------+---------------
//   s_axis   | in        | position[7:0], entry_value[31:0] | opcode[2:0]
//   m_axis   | out       | removed_value[31:0], entry_count[7:0] | status[1:0]
//
// One operation is worked at a time. An insert below the count moves every
// entry from its position up one slot, and a removal every entry above its
// position down one slot; an append or a refused or unused operation moves
// none. The list memory moves one entry per cycle through its single read
// and single write port.
// Reset (synchronous, active low) empties the list at once; memory contents
// are not cleared since entries above the count are never read.
// A result waits in the output register while the next operation is accepted
// and worked; the sequencer stalls only if a second result is ready first.
module sequential_list_shift_engine_core #(
    parameter int DEPTH       = 128,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position[7:0], entry_value[39:8]
    input  logic [slse_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode[2:0]
    input  logic [slse_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // removed_value[31:0], entry_count[39:32]
    output logic [slse_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status[1:0]
    output logic [slse_pkg::STAT_W-1:0]       m_axis_tuser
);
    import slse_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                   res_valid;
    logic                   res_ready;
    t_result                res;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [ENTRY_WIDTH-1:0] mem_rdata;

    logic    r_out_valid;
    t_result r_out;

    slse_ctrl #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_position  (s_axis_tdata[POS_W-1:0]),
        .i_entry     (s_axis_tdata[POS_W +: VAL_W]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    slse_mem #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The result register takes a new result when empty or when its current
    // transfer completes in the same cycle.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.count, r_out.removed};
    assign m_axis_tuser  = r_out.status;

endmodule

### design/slse_checker.sv
// Port-level checks for the sequential list shift engine.
// Depends on slse_pkg; bound to sequential_list_shift_engine_core below.
module slse_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [slse_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [slse_pkg::STAT_W-1:0]       m_axis_tuser
);
    import slse_pkg::*;

    // A held result must not change until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Only one operation is in work: input is closed right after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened directly after a transfer");

    // A refused operation returns no entry.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_DONE) |-> m_axis_tdata[VAL_W-1:0] == '0)
        else $error("refused operation returned an entry");

    // The status code is never the unused encoding.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_DONE) || (m_axis_tuser == ST_INS_REFUSED)
                          || (m_axis_tuser == ST_REM_REFUSED))
        else $error("unused status code on output");

endmodule

bind sequential_list_shift_engine_core slse_checker u_slse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_sequential_list_shift_engine_core.sv
// Self-checking testbench for sequential_list_shift_engine_core.
// Holds a list scoreboard class, stream drivers and the run control.
// Depends on slse_pkg and the engine top level only.
module tb_sequential_list_shift_engine_core;

    import slse_pkg::*;

    localparam int unsigned LIST_DEPTH   = 128;
    // Roughly 20 directed operations come first; the random part brings the total near 850.
    localparam int unsigned RANDOM_OPS   = 830;
    // The limit covers the slowest legal run, about 850 ops that each shift
    // the whole list, with idle gaps on each side and one long receiver hold,
    // several times over.
    localparam int unsigned CYCLE_LIMIT  = 800_000;
    // Cycles to keep watching the result port after the last expected
    // transfer. One full shift of the list fits inside this window.
    localparam int unsigned DRAIN_CYCLES = LIST_DEPTH + 20;
    // The receiver holds off once this many results have been taken.
    localparam int unsigned HOLD_AFTER   = 200;
    localparam int unsigned HOLD_CYCLES  = 400;

    // Opcodes 6 and 7 have no operation behind them and must act as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // Scoreboard: a queue models the list itself, so inserts and removes map
    // directly onto queue insert and delete. Every accepted operation is
    // worked here at once and its expected result is queued in order.
    class list_scoreboard;
        logic [VAL_W-1:0] entries[$];
        t_result          awaited[$];
        int unsigned      depth;
        int unsigned      mismatches;

        function new(int unsigned depth_i);
            depth      = depth_i;
            mismatches = 0;
        endfunction

        function int unsigned held();
            return entries.size();
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
            t_result     res;
            int unsigned cnt;
            int unsigned at;
            cnt         = entries.size();
            res.removed = '0;
            res.status  = ST_DONE;
            case (op)
                OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                    if (op == OP_INS_FRONT) at = 0;
                    else if (op == OP_INS_BACK) at = cnt;
                    else at = pos;
                    // A full list refuses every insert, even an append.
                    if (cnt >= depth || at > cnt) res.status = ST_INS_REFUSED;
                    else entries.insert(at, val);
                end
                OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                    if (cnt == 0) begin
                        res.status = ST_REM_REFUSED;
                    end else begin
                        if (op == OP_REM_FRONT) at = 0;
                        else if (op == OP_REM_BACK) at = cnt - 1;
                        else at = pos;
                        if (at >= cnt) begin
                            res.status = ST_REM_REFUSED;
                        end else begin
                            res.removed = entries[at];
                            entries.delete(at);
                        end
                    end
                end
                default: ;
            endcase
            res.count = CNT_OUT_W'(entries.size());
            awaited.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] user);
            t_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: removed_value %h status %0d entry_count %0d",
                       data[31:0], user, data[39:32]);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (data[31:0] !== want.removed) begin
                $error("removed_value: expected %h, got %h", want.removed, data[31:0]);
                mismatches++;
            end
            if (user !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, user);
                mismatches++;
            end
            if (data[39:32] !== want.count) begin
                $error("entry_count: expected %0d, got %0d", want.count, data[39:32]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // position[7:0], entry_value[39:8]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // opcode[2:0]
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // removed_value[31:0], entry_count[39:32]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // status[1:0]
    logic [STAT_W-1:0]     m_axis_tuser;

    list_scoreboard sb = new(LIST_DEPTH);
    int unsigned    cycle_count = 0;

    sequential_list_shift_engine_core #(
        .DEPTH       (LIST_DEPTH),
        .ENTRY_WIDTH (VAL_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog. A hung handshake or a lost result ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle gap length: one pick in ten comes from the long range, the rest from the short one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // Offers one operation and waits for its transfer. The valid line stays
    // high into the next call unless an idle gap is chosen, so it is never
    // lowered and raised within one time step.
    task automatic offer_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val, input bit no_gap);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, pos};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, pos, val);
        gap = (no_gap || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side. Each cycle it takes any completed transfer to the
    // scoreboard and then decides the ready level for the next edge. Once in
    // the run it holds off for a long stretch so that the engine backs up and
    // stops taking operations; every third block of 50 results it never stalls.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned taken;
        bit          hold_done;
        stall_left = 0;
        taken      = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
                taken++;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && taken >= HOLD_AFTER) begin
                hold_done     = 1'b1;
                stall_left    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if ((taken / 50) % 3 == 2) begin
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left    = pick_gap() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : op_source
        int unsigned      n;
        int unsigned      cnt;
        int unsigned      turn_hits;
        bit               growing;
        bit               want_insert;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. It starts on the empty list, where every removal must
        // be refused, builds a short list with the extreme entry words, takes
        // it apart again through each kind of removal, and tries both spare
        // opcodes on the way. Inserts past the count and removals at or past
        // the count are refused; an insert at exactly the count appends.
        offer_op(OP_REM_FRONT, 8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_REM_BACK,  8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_REM_AT,    8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_SPARE_LO,  8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_INS_AT,    8'd1,   32'h1111_1111, 1'b0);
        offer_op(OP_INS_FRONT, 8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_INS_BACK,  8'd0,   32'hFFFF_FFFF, 1'b1);
        offer_op(OP_INS_AT,    8'd2,   32'hA5A5_A5A5, 1'b0);
        offer_op(OP_INS_AT,    8'd0,   32'h5A5A_5A5A, 1'b1);
        offer_op(OP_INS_AT,    8'd2,   32'h1234_5678, 1'b0);
        offer_op(OP_INS_AT,    8'd255, 32'hDEAD_BEEF, 1'b0);
        offer_op(OP_SPARE_HI,  8'd255, 32'hFFFF_FFFF, 1'b0);
        offer_op(OP_REM_AT,    8'd5,   32'h0000_0000, 1'b0);
        offer_op(OP_REM_AT,    8'd255, 32'hFFFF_FFFF, 1'b0);
        offer_op(OP_REM_AT,    8'd2,   32'h0000_0000, 1'b1);
        offer_op(OP_REM_BACK,  8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_REM_FRONT, 8'd0,   32'h0000_0000, 1'b1);
        offer_op(OP_REM_AT,    8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_REM_AT,    8'd0,   32'h0000_0000, 1'b0);
        offer_op(OP_REM_BACK,  8'd0,   32'h0000_0000, 1'b0);

        // Random part. The list swings between growing and shrinking phases so
        // that it fills completely, meets a few refused inserts while full, and
        // then drains to empty. Positions mostly fall in the legal range; some
        // are drawn from the whole byte, and about one operation in twelve is
        // pure noise with any opcode at all.
        growing   = 1'b1;
        turn_hits = 0;
        for (n = 0; n < RANDOM_OPS; n++) begin
            cnt = sb.held();
            if ((growing && cnt == LIST_DEPTH) || (!growing && cnt == 0)) begin
                turn_hits++;
                if (turn_hits > 4) begin
                    growing   = !growing;
                    turn_hits = 0;
                end
            end
            val = $urandom();
            if ($urandom_range(0, 11) == 0) begin
                op  = OP_W'($urandom_range(0, 7));
                pos = POS_W'($urandom_range(0, 255));
            end else begin
                want_insert = ($urandom_range(0, 99) < (growing ? 75 : 25));
                if (want_insert) begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_INS_FRONT;
                        1:       op = OP_INS_BACK;
                        default: op = OP_INS_AT;
                    endcase
                    pos = POS_W'($urandom_range(0, cnt));
                end else begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_REM_FRONT;
                        1:       op = OP_REM_BACK;
                        default: op = OP_REM_AT;
                    endcase
                    pos = (cnt == 0) ? '0 : POS_W'($urandom_range(0, cnt - 1));
                end
                if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 255));
            end
            offer_op(op, pos, val, ((n / 64) % 3 == 1));
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every outstanding result, then watch a little longer so
        // that a stray extra transfer is still caught.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
